FILE: hw/rtl/gdh_pkg.sv
// gdh_pkg: shared widths, codes and types of the degree histogram block
// no dependencies; imported by the front, back and top level
package gdh_pkg;

   localparam int VTX_W = 7;   // one-based vertex id on the request
   localparam int CFG_W = 7;   // vertex count register
   localparam int DEG_W = 6;   // per-vertex degree counter
   localparam int CNT_W = 7;   // histogram bin count
   localparam int BIN_W = 6;   // degree field of a response

   localparam logic [DEG_W-1:0] DEG_SAT = 6'd63;

   localparam logic KIND_EDGE   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] vertex_count;   // already clamped to 1..MAX_VERTICES
   } cfg_type;

   typedef struct packed {
      logic [BIN_W-1:0] degree;
      logic [CNT_W-1:0] out_count;
      logic [CNT_W-1:0] in_count;
      logic             last;
   } rsp_type;

endpackage

FILE: hw/rtl/graph_degree_histogram.sv
// graph_degree_histogram: out- and in-degree distribution of a directed edge stream
// edge request: one per cycle sustained while the back is idle, no response; degree RAM
//   update is a two-stage read-modify-write with forwarding of the previous write
// finish request: walks all MAX_VERTICES entries of the degree RAMs, lets the histogram
//   updates drain, then n responses at up to one per cycle as the response queue has room
// reset: synchronous; a clearing pass over MAX_VERTICES entries zeroes all RAMs, req_full high
// depends on gdh_pkg, gdh_front, gdh_queue and gdh_back
module graph_degree_histogram #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_kind,
   input  logic [gdh_pkg::VTX_W-1:0]     req_source_vertex,
   input  logic [gdh_pkg::VTX_W-1:0]     req_target_vertex,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [gdh_pkg::BIN_W-1:0]     rsp_degree,
   output logic [gdh_pkg::CNT_W-1:0]     rsp_out_count,
   output logic [gdh_pkg::CNT_W-1:0]     rsp_in_count,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gdh_pkg::CFG_W-1:0]     csr_data
);

   import gdh_pkg::*;

   localparam int CMD_W     = 2 * $clog2(MAX_VERTICES) + 1;
   localparam int CMD_DEPTH = 4;

   cfg_type          cfg;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CMD_W-1:0] cmd_entry, cmd_head;
   logic             clearing;
   rsp_type          rsp;

   gdh_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_kind          (req_kind),
      .req_source_vertex (req_source_vertex),
      .req_target_vertex (req_target_vertex),
      .cmd_full          (cmd_full),
      .clearing          (clearing),
      .cmd_push          (cmd_push),
      .cmd_entry         (cmd_entry),
      .cfg               (cfg)
   );

   gdh_queue #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .data_in (cmd_entry),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .head    (cmd_head)
   );

   gdh_back #(.MAX_VERTICES(MAX_VERTICES), .OUT_DEPTH(4)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .clearing  (clearing),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_degree    = rsp.degree;
   assign rsp_out_count = rsp.out_count;
   assign rsp_in_count  = rsp.in_count;
   assign rsp_last      = rsp.last;

endmodule

FILE: hw/rtl/gdh_ram.sv
// gdh_ram: generic single write port, single read port RAM with registered read
// no dependencies; a read at the written address returns the old data
module gdh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/gdh_queue.sv
// gdh_queue: small register FIFO with full and empty flags
// no dependencies; used for the request queue and the response queue
module gdh_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] count_ff, count_in;
   logic             push_acc, pop_acc;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full     = (count_ff == LVL_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_acc = push && !full;
   assign pop_acc  = pop && !empty;
   assign head     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_acc ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_acc ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      case ({push_acc, pop_acc})
         2'b10:   count_in = count_ff + LVL_W'(1);
         2'b01:   count_in = count_ff - LVL_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_acc) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

FILE: hw/rtl/gdh_front.sv
// gdh_front: vertex count register, request accept and edge classification
// depends on gdh_pkg; feeds the request queue with finish items and valid edges
module gdh_front #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gdh_pkg::CFG_W-1:0]            csr_data,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_kind,
   input  logic [gdh_pkg::VTX_W-1:0]            req_source_vertex,
   input  logic [gdh_pkg::VTX_W-1:0]            req_target_vertex,
   input  logic                                 cmd_full,
   input  logic                                 clearing,
   output logic                                 cmd_push,
   output logic [2*$clog2(MAX_VERTICES):0]      cmd_entry,
   output gdh_pkg::cfg_type                     cfg
);

   import gdh_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam logic [CFG_W-1:0] MAX_COUNT = CFG_W'(MAX_VERTICES);

   logic [CFG_W-1:0] count_ff, count_in;
   logic             accept;
   logic             edge_ok;
   logic [VTX_W-1:0] src_m1, dst_m1;

   // store the clamped count so every user sees 1..MAX_VERTICES
   always_comb begin
      count_in = count_ff;
      if (csr_valid) begin
         if (csr_data == '0) begin
            count_in = CFG_W'(1);
         end else if (csr_data > MAX_COUNT) begin
            count_in = MAX_COUNT;
         end else begin
            count_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= MAX_COUNT;
      end else begin
         count_ff <= count_in;
      end
   end

   assign csr_ready        = 1'b1;
   assign cfg.vertex_count = count_ff;

   assign req_full = cmd_full || clearing;
   assign accept   = req_push && !req_full;

   assign edge_ok = (req_source_vertex != '0) && (CFG_W'(req_source_vertex) <= count_ff) &&
                    (req_target_vertex != '0) && (CFG_W'(req_target_vertex) <= count_ff);

   // an edge with an id out of range is dropped here and never reaches the back
   assign cmd_push = accept && ((req_kind == KIND_FINISH) || edge_ok);

   assign src_m1    = req_source_vertex - VTX_W'(1);
   assign dst_m1    = req_target_vertex - VTX_W'(1);
   assign cmd_entry = {req_kind, src_m1[IDX_W-1:0], dst_m1[IDX_W-1:0]};

endmodule

FILE: hw/rtl/gdh_back.sv
// gdh_back: degree RAMs, histogram RAMs, finish sequencer and response queue
// depends on gdh_pkg, gdh_ram and gdh_queue; drains the request queue
module gdh_back #(
   parameter int MAX_VERTICES = 64,
   parameter int OUT_DEPTH    = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gdh_pkg::cfg_type                 cfg,
   input  logic                             cmd_empty,
   input  logic [2*$clog2(MAX_VERTICES):0]  cmd_head,
   output logic                             cmd_pop,
   output logic                             clearing,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output gdh_pkg::rsp_type                 rsp
);

   import gdh_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int LVL_W = $clog2(OUT_DEPTH + 1);
   localparam int RSP_W = $bits(rsp_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_VERTICES - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_WAIT  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             wait_ff, wait_in;

   logic             head_kind;
   logic [IDX_W-1:0] head_src, head_dst;
   logic             edge_pop, fin_pop;
   logic [CFG_W-1:0] n_last_full;
   logic [IDX_W-1:0] n_last;

   // edge pipeline: read stage then update stage
   logic             b_valid_ff;
   logic [IDX_W-1:0] b_src_ff, b_dst_ff;

   logic             od_we, id_we;
   logic [IDX_W-1:0] od_waddr, id_waddr, od_raddr, id_raddr;
   logic [DEG_W-1:0] od_wdata, id_wdata, od_rdata, id_rdata, od_cur, id_cur;
   logic             odl_valid_ff, idl_valid_ff;
   logic [IDX_W-1:0] odl_addr_ff, idl_addr_ff;
   logic [DEG_W-1:0] odl_data_ff, idl_data_ff;

   // walk pipeline: degree read, bin and histogram read, histogram update
   logic             d_valid_ff, d_count_ff;
   logic [IDX_W-1:0] o_bin, i_bin;
   logic             h_valid_ff;
   logic [IDX_W-1:0] h_obin_ff, h_ibin_ff;

   logic             oh_we, ih_we;
   logic [IDX_W-1:0] oh_waddr, ih_waddr, oh_raddr, ih_raddr;
   logic [CNT_W-1:0] oh_wdata, ih_wdata, oh_rdata, ih_rdata, oh_cur, ih_cur;
   logic             ohl_valid_ff, ihl_valid_ff;
   logic [IDX_W-1:0] ohl_addr_ff, ihl_addr_ff;
   logic [CNT_W-1:0] ohl_data_ff, ihl_data_ff;

   // emission
   logic             emit_issue;
   logic             e_valid_ff;
   logic [IDX_W-1:0] e_idx_ff;
   logic             e_last_ff;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             rsp_acc;
   logic             out_full;
   rsp_type          out_data;
   logic [RSP_W-1:0] out_head;

   function automatic logic [IDX_W-1:0] bin_of(input logic [DEG_W-1:0] deg,
                                                input logic [CFG_W-1:0] lim);
      logic [CFG_W-1:0] d;
      logic [CFG_W-1:0] b;
      d = CFG_W'(deg);
      b = (d > lim) ? lim : d;
      return b[IDX_W-1:0];
   endfunction

   assign head_kind = cmd_head[2*IDX_W];
   assign head_src  = cmd_head[2*IDX_W-1:IDX_W];
   assign head_dst  = cmd_head[IDX_W-1:0];

   assign n_last_full = cfg.vertex_count - CFG_W'(1);
   assign n_last      = n_last_full[IDX_W-1:0];

   assign clearing = (state_ff == ST_CLEAR);
   assign cmd_pop  = (state_ff == ST_IDLE) && !cmd_empty;
   assign edge_pop = cmd_pop && (head_kind == KIND_EDGE);
   assign fin_pop  = cmd_pop && (head_kind == KIND_FINISH);

   assign rsp_acc    = rsp_pop && !rsp_empty;
   assign emit_issue = (state_ff == ST_EMIT) && (level_ff < LVL_W'(OUT_DEPTH));

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      wait_in  = wait_ff;
      case (state_ff)
         ST_CLEAR: begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
               idx_in   = '0;
            end
         end
         ST_IDLE: begin
            if (fin_pop) begin
               state_in = ST_WALK;
               idx_in   = '0;
            end
         end
         ST_WALK: begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_WAIT;
               idx_in   = '0;
               wait_in  = 1'b0;
            end
         end
         ST_WAIT: begin
            // let the last two histogram updates land before reading bins
            wait_in = 1'b1;
            if (wait_ff) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end
         end
         ST_EMIT: begin
            if (emit_issue) begin
               if (idx_ff == n_last) begin
                  state_in = ST_IDLE;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         wait_ff  <= wait_in;
      end
   end

   // ---------------- degree RAMs ----------------
   assign od_raddr = (state_ff == ST_WALK) ? idx_ff : head_src;
   assign id_raddr = (state_ff == ST_WALK) ? idx_ff : head_dst;

   // forward the write of the previous cycle, the RAM returns old data for it
   assign od_cur = (odl_valid_ff && (odl_addr_ff == b_src_ff)) ? odl_data_ff : od_rdata;
   assign id_cur = (idl_valid_ff && (idl_addr_ff == b_dst_ff)) ? idl_data_ff : id_rdata;

   always_comb begin
      od_we    = 1'b0;
      od_waddr = b_src_ff;
      od_wdata = (od_cur == DEG_SAT) ? od_cur : od_cur + DEG_W'(1);
      id_we    = 1'b0;
      id_waddr = b_dst_ff;
      id_wdata = (id_cur == DEG_SAT) ? id_cur : id_cur + DEG_W'(1);
      if ((state_ff == ST_CLEAR) || (state_ff == ST_WALK)) begin
         od_we    = 1'b1;
         od_waddr = idx_ff;
         od_wdata = '0;
         id_we    = 1'b1;
         id_waddr = idx_ff;
         id_wdata = '0;
      end else if (b_valid_ff) begin
         od_we = 1'b1;
         id_we = 1'b1;
      end
   end

   gdh_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_out_deg_ram (
      .clock (clock),
      .we    (od_we),
      .waddr (od_waddr),
      .wdata (od_wdata),
      .raddr (od_raddr),
      .rdata (od_rdata)
   );

   gdh_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_in_deg_ram (
      .clock (clock),
      .we    (id_we),
      .waddr (id_waddr),
      .wdata (id_wdata),
      .raddr (id_raddr),
      .rdata (id_rdata)
   );

   // ---------------- histogram RAMs ----------------
   assign o_bin = bin_of(od_rdata, n_last_full);
   assign i_bin = bin_of(id_rdata, n_last_full);

   assign oh_raddr = (state_ff == ST_EMIT) ? idx_ff : o_bin;
   assign ih_raddr = (state_ff == ST_EMIT) ? idx_ff : i_bin;

   assign oh_cur = (ohl_valid_ff && (ohl_addr_ff == h_obin_ff)) ? ohl_data_ff : oh_rdata;
   assign ih_cur = (ihl_valid_ff && (ihl_addr_ff == h_ibin_ff)) ? ihl_data_ff : ih_rdata;

   always_comb begin
      oh_we    = 1'b0;
      oh_waddr = h_obin_ff;
      oh_wdata = oh_cur + CNT_W'(1);
      ih_we    = 1'b0;
      ih_waddr = h_ibin_ff;
      ih_wdata = ih_cur + CNT_W'(1);
      if ((state_ff == ST_CLEAR) || emit_issue) begin
         // a bin is cleared in the cycle it is read out
         oh_we    = 1'b1;
         oh_waddr = idx_ff;
         oh_wdata = '0;
         ih_we    = 1'b1;
         ih_waddr = idx_ff;
         ih_wdata = '0;
      end else if (h_valid_ff) begin
         oh_we = 1'b1;
         ih_we = 1'b1;
      end
   end

   gdh_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_out_hist_ram (
      .clock (clock),
      .we    (oh_we),
      .waddr (oh_waddr),
      .wdata (oh_wdata),
      .raddr (oh_raddr),
      .rdata (oh_rdata)
   );

   gdh_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_in_hist_ram (
      .clock (clock),
      .we    (ih_we),
      .waddr (ih_waddr),
      .wdata (ih_wdata),
      .raddr (ih_raddr),
      .rdata (ih_rdata)
   );

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         odl_valid_ff <= 1'b0;
         idl_valid_ff <= 1'b0;
         d_valid_ff   <= 1'b0;
         h_valid_ff   <= 1'b0;
         ohl_valid_ff <= 1'b0;
         ihl_valid_ff <= 1'b0;
         e_valid_ff   <= 1'b0;
      end else begin
         b_valid_ff   <= edge_pop;
         odl_valid_ff <= od_we;
         idl_valid_ff <= id_we;
         d_valid_ff   <= (state_ff == ST_WALK);
         h_valid_ff   <= d_valid_ff && d_count_ff;
         ohl_valid_ff <= oh_we;
         ihl_valid_ff <= ih_we;
         e_valid_ff   <= emit_issue;
      end
   end

   always_ff @(posedge clock) begin
      b_src_ff    <= head_src;
      b_dst_ff    <= head_dst;
      odl_addr_ff <= od_waddr;
      odl_data_ff <= od_wdata;
      idl_addr_ff <= id_waddr;
      idl_data_ff <= id_wdata;
      // vertices at or beyond the count are cleared but not binned
      d_count_ff  <= (CFG_W'(idx_ff) < cfg.vertex_count);
      h_obin_ff   <= o_bin;
      h_ibin_ff   <= i_bin;
      ohl_addr_ff <= oh_waddr;
      ohl_data_ff <= oh_wdata;
      ihl_addr_ff <= ih_waddr;
      ihl_data_ff <= ih_wdata;
      e_idx_ff    <= idx_ff;
      e_last_ff   <= (idx_ff == n_last);
   end

   // ---------------- response queue ----------------
   // slots are reserved when a bin read issues, so the queue never overflows
   always_comb begin
      case ({emit_issue, rsp_acc})
         2'b10:   level_in = level_ff + LVL_W'(1);
         2'b01:   level_in = level_ff - LVL_W'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   assign out_data.degree    = BIN_W'(e_idx_ff);
   assign out_data.out_count = oh_rdata;
   assign out_data.in_count  = ih_rdata;
   assign out_data.last      = e_last_ff;

   gdh_queue #(.WIDTH(RSP_W), .DEPTH(OUT_DEPTH)) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (e_valid_ff),
      .data_in (out_data),
      .full    (out_full),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .head    (out_head)
   );

   assign rsp = rsp_type'(out_head);

   // ---------------- assertions ----------------
   a_walk_no_edge_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> !b_valid_ff)
      else $error("edge update overlaps the degree walk");

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> !out_full)
      else $error("response pushed into a full queue");

   a_hist_update_window: assert property (@(posedge clock) disable iff (reset)
      h_valid_ff |-> ((state_ff == ST_WALK) || (state_ff == ST_WAIT)))
      else $error("histogram update outside the walk");

   a_finish_starts_walk: assert property (@(posedge clock) disable iff (reset)
      fin_pop |=> ((state_ff == ST_WALK) && (idx_ff == '0)))
      else $error("finish request did not start the walk at vertex zero");

endmodule
